>>> hdl/qsu_pkg.sv
// Shared definitions for the quoted string unescaper.
// Result kinds, error codes and the special character codes.
// No dependencies.
package qsu_pkg;

	localparam int unsigned CharW = 8;

	typedef logic [CharW-1:0] char_t;
	typedef logic [1:0] kind_t;
	typedef logic [1:0] err_t;

	localparam kind_t KIND_NONE = 2'd0;
	localparam kind_t KIND_DATA = 2'd1;
	localparam kind_t KIND_END  = 2'd2;
	localparam kind_t KIND_ERR  = 2'd3;

	localparam err_t ERR_PLAIN  = 2'd0;
	localparam err_t ERR_ESCAPE = 2'd1;
	localparam err_t ERR_BIG    = 2'd2;

	localparam char_t CHAR_QUOTE     = 8'h27;
	localparam char_t CHAR_BACKSLASH = 8'h5C;
	localparam char_t CHAR_CR        = 8'h0D;
	localparam char_t CHAR_LF        = 8'h0A;
	localparam char_t CHAR_ZERO      = 8'h30;
	localparam char_t CHAR_SEVEN     = 8'h37;
	localparam char_t PRINT_LO       = 8'd32;
	localparam char_t PRINT_HI       = 8'd126;

endpackage

>>> hdl/quoted_string_unescape.sv
// Quoted string unescaper: one input register, decode logic, one result register.
// Depends on qsu_pkg for result kinds, error codes and character codes.
// Holds the escape mode and the partial octal value between transactions.

// Decodes the body of a single-quoted string, one byte per transaction,
// starting just after the opening quote, and returns exactly one result per
// byte: nothing (the byte was part of an escape), a data byte, end of string
// or an error with its cause. Escapes are backslash followed by quote,
// backslash, CR, LF or exactly three octal digits. After an end or an error
// the next byte starts a new string body. A byte's result goes from the input
// register through the decode logic into the result register, and a new byte
// is accepted every cycle as long as the result side keeps up; the only
// feedback is the mode and partial octal value registers, updated once per byte.
module quoted_string_unescape (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  qsu_pkg::char_t       in_char,
	output logic                 out_valid,
	input  logic                 out_ready,
	output qsu_pkg::kind_t       kind,
	output qsu_pkg::char_t       data_byte,
	output qsu_pkg::err_t        error_kind
);

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_ESC,
		MODE_OCT1,
		MODE_OCT2
	} mode_t;

	logic           valid_s1;
	qsu_pkg::char_t char_s1;
	mode_t          mode_q;
	logic [5:0]     acc_q;

	logic           advance;
	logic           load_s1;
	logic           is_oct;
	logic [2:0]     digit;
	logic [8:0]     oct_val;
	mode_t          mode_d;
	logic [5:0]     acc_d;
	qsu_pkg::kind_t res_kind;
	qsu_pkg::char_t res_data;
	qsu_pkg::err_t  res_err;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign load_s1  = in_valid && in_ready;

	assign is_oct  = (char_s1 >= qsu_pkg::CHAR_ZERO) && (char_s1 <= qsu_pkg::CHAR_SEVEN);
	assign digit   = char_s1[2:0];
	assign oct_val = {acc_q, 3'b000} + {6'd0, digit};

	always_comb begin
		mode_d   = mode_q;
		acc_d    = acc_q;
		res_kind = qsu_pkg::KIND_NONE;
		res_data = '0;
		res_err  = qsu_pkg::ERR_PLAIN;
		case (mode_q)
			MODE_NORMAL: begin
				if (char_s1 == qsu_pkg::CHAR_QUOTE) begin
					res_kind = qsu_pkg::KIND_END;
				end else if (char_s1 == qsu_pkg::CHAR_BACKSLASH) begin
					mode_d = MODE_ESC;
					acc_d  = '0;
				end else if (char_s1 inside {[qsu_pkg::PRINT_LO:qsu_pkg::PRINT_HI]}) begin
					res_kind = qsu_pkg::KIND_DATA;
					res_data = char_s1;
				end else begin
					res_kind = qsu_pkg::KIND_ERR;
					res_err  = qsu_pkg::ERR_PLAIN;
				end
			end
			MODE_ESC: begin
				if (char_s1 inside {qsu_pkg::CHAR_QUOTE, qsu_pkg::CHAR_BACKSLASH,
						qsu_pkg::CHAR_CR, qsu_pkg::CHAR_LF}) begin
					mode_d   = MODE_NORMAL;
					res_kind = qsu_pkg::KIND_DATA;
					res_data = char_s1;
				end else if (is_oct) begin
					mode_d = MODE_OCT1;
					acc_d  = {3'd0, digit};
				end else begin
					res_kind = qsu_pkg::KIND_ERR;
					res_err  = qsu_pkg::ERR_ESCAPE;
				end
			end
			MODE_OCT1: begin
				if (is_oct) begin
					mode_d = MODE_OCT2;
					acc_d  = oct_val[5:0];
				end else begin
					res_kind = qsu_pkg::KIND_ERR;
					res_err  = qsu_pkg::ERR_ESCAPE;
				end
			end
			MODE_OCT2: begin
				if (!is_oct) begin
					res_kind = qsu_pkg::KIND_ERR;
					res_err  = qsu_pkg::ERR_ESCAPE;
				end else if (oct_val[8]) begin
					res_kind = qsu_pkg::KIND_ERR;
					res_err  = qsu_pkg::ERR_BIG;
				end else begin
					mode_d   = MODE_NORMAL;
					acc_d    = '0;
					res_kind = qsu_pkg::KIND_DATA;
					res_data = oct_val[7:0];
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
			end
		endcase
		// Both an end and an error leave the decoder ready for a new body.
		if (res_kind == qsu_pkg::KIND_END || res_kind == qsu_pkg::KIND_ERR) begin
			mode_d = MODE_NORMAL;
			acc_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
			mode_q    <= MODE_NORMAL;
			acc_q     <= '0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid <= 1'b1;
				mode_q    <= mode_d;
				acc_q     <= acc_d;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			char_s1 <= in_char;
		end
		if (advance) begin
			kind       <= res_kind;
			data_byte  <= res_data;
			error_kind <= res_err;
		end
	end

`ifndef SYNTHESIS
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != qsu_pkg::KIND_DATA |-> data_byte == '0)
		else $error("data byte not zero on a non-data result");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != qsu_pkg::KIND_ERR |-> error_kind == qsu_pkg::ERR_PLAIN)
		else $error("error code set on a non-error result");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_kind != 2'd3)
		else $error("undefined error code");

	a_mode_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (res_kind == qsu_pkg::KIND_END || res_kind == qsu_pkg::KIND_ERR)
		|=> mode_q == MODE_NORMAL && acc_q == '0)
		else $error("mode not cleared after end or error");
`endif

endmodule
